### rtl/ofdm_cyclic_prefix_inserter_macros.svh
// Assertion macros shared by the cyclic prefix inserter RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef OFDM_CYCLIC_PREFIX_INSERTER_MACROS_SVH
`define OFDM_CYCLIC_PREFIX_INSERTER_MACROS_SVH

// Same-cycle implication.
`define OCPI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OCPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ocpi_pkg.sv
// Types and constants of the OFDM cyclic prefix inserter.
// No dependencies; imported by ocpi_front, ocpi_fifo and the top module.
`timescale 1ns / 1ps

package ocpi_pkg;

  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int SAMPLE_W    = 32;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYMBOL_LEN       = 2'd0,
    CFG_PREFIX_LEN       = 2'd1,
    CFG_FIRST_PREFIX_LEN = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DATA      = 2'd0,
    ST_DROPPED   = 2'd1,
    ST_DISCARDED = 2'd2
  } status_e;

  typedef struct packed {
    logic [CFG_W-1:0] symbol_len;
    logic [CFG_W-1:0] prefix_len;
    logic [CFG_W-1:0] first_prefix_len;
  } cfg_t;

  typedef struct packed {
    logic    valid;
    logic    is_data;
    logic    last;
    status_e status;
  } res_ctl_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    status_e             status;
  } result_t;

endpackage

### rtl/ocpi_store.sv
// Two-bank symbol store: one write port and one registered read port.
// Uses no package items; sized by the address and data width parameters.
`timescale 1ns / 1ps

module ocpi_store #(
  parameter int AW = 12,
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ocpi_front.sv
// Front end: accepts pushes and ticks, keeps bank and read state, drives the store.
// Depends on ocpi_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "ofdm_cyclic_prefix_inserter_macros.svh"

module ocpi_front
  import ocpi_pkg::*;
#(
  parameter int MAX_SYMBOL  = 2048,
  parameter int SAMPLE_BITS = 32,
  localparam int IW = $clog2(MAX_SYMBOL),
  localparam int LW = $clog2(MAX_SYMBOL + 1),
  localparam int AW = IW + 1,
  localparam int SW = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                accept_i,
  input  op_e                 op_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                frame_start_i,
  output logic                mem_we_o,
  output logic [AW-1:0]       mem_waddr_o,
  output logic [SW-1:0]       mem_wdata_o,
  output logic                mem_re_o,
  output logic [AW-1:0]       mem_raddr_o,
  output res_ctl_t            res_o
);

  logic [IW-1:0] wi_q, wi_d, wi_v;
  logic          wb_q, wb_d;
  logic [1:0]    bank_full_q, bank_full_d;
  logic [1:0]    bank_first_q, bank_first_d;
  logic          pend_q, pend_d;
  logic          rb_q, rb_d;
  logic [LW:0]   rc_q, rc_d;
  res_ctl_t      res_q, res_d;

  logic [LW-1:0]    eff_len;
  logic [CFG_W-1:0] p_raw;
  logic [LW-1:0]    p_len;
  logic [LW:0]      total;
  logic [LW:0]      k;
  logic [LW:0]      idx;
  logic             is_last;

  always_comb begin
    if (cfg_i.symbol_len == '0) begin
      eff_len = LW'(1);
    end else if (32'(cfg_i.symbol_len) > MAX_SYMBOL) begin
      eff_len = LW'(MAX_SYMBOL);
    end else begin
      eff_len = LW'(cfg_i.symbol_len);
    end
    p_raw = bank_first_q[rb_q] ? cfg_i.first_prefix_len : cfg_i.prefix_len;
    if (32'(p_raw) > 32'(eff_len)) begin
      p_len = eff_len;
    end else begin
      p_len = LW'(p_raw);
    end
    total   = {1'b0, p_len} + {1'b0, eff_len};
    k       = (rc_q < total) ? rc_q : total - (LW+1)'(1);
    idx     = (k < {1'b0, p_len}) ? ({1'b0, eff_len} - {1'b0, p_len} + k)
                                  : (k - {1'b0, p_len});
    is_last = (k == total - (LW+1)'(1));
  end

  always_comb begin
    wi_d         = wi_q;
    wb_d         = wb_q;
    bank_full_d  = bank_full_q;
    bank_first_d = bank_first_q;
    pend_d       = pend_q;
    rb_d         = rb_q;
    rc_d         = rc_q;
    res_d        = '0;
    wi_v         = wi_q;
    mem_we_o     = 1'b0;
    mem_re_o     = 1'b0;
    if (accept_i) begin
      if (op_i == OP_TICK) begin
        if (bank_full_q[rb_q]) begin
          mem_re_o      = 1'b1;
          res_d.valid   = 1'b1;
          res_d.is_data = 1'b1;
          res_d.last    = is_last;
          res_d.status  = ST_DATA;
          if (is_last) begin
            bank_full_d[rb_q] = 1'b0;
            rb_d              = ~rb_q;
            rc_d              = '0;
          end else begin
            rc_d = k + (LW+1)'(1);
          end
        end
      end else begin
        if (frame_start_i) begin
          pend_d = 1'b1;
          if (wi_q != '0) begin
            wi_v         = '0;
            res_d.valid  = 1'b1;
            res_d.status = ST_DISCARDED;
          end
        end
        wi_d = wi_v;
        if (bank_full_q[wb_q]) begin
          res_d.valid  = 1'b1;
          res_d.status = ST_DROPPED;
        end else begin
          if (wi_v == '0) begin
            bank_first_d[wb_q] = pend_d;
            pend_d             = 1'b0;
          end
          mem_we_o = 1'b1;
          if (LW'(wi_v) + LW'(1) >= eff_len) begin
            bank_full_d[wb_q] = 1'b1;
            wb_d              = ~wb_q;
            wi_d              = '0;
          end else begin
            wi_d = wi_v + IW'(1);
          end
        end
      end
    end
  end

  assign mem_waddr_o = {wb_q, wi_v};
  assign mem_wdata_o = SW'(sample_i);
  assign mem_raddr_o = {rb_q, idx[IW-1:0]};
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q         <= '0;
      wb_q         <= 1'b0;
      bank_full_q  <= '0;
      bank_first_q <= '0;
      pend_q       <= 1'b1;
      rb_q         <= 1'b0;
      rc_q         <= '0;
      res_q        <= '0;
    end else begin
      wi_q         <= wi_d;
      wb_q         <= wb_d;
      bank_full_q  <= bank_full_d;
      bank_first_q <= bank_first_d;
      pend_q       <= pend_d;
      rb_q         <= rb_d;
      rc_q         <= rc_d;
      res_q        <= res_d;
    end
  end

  `OCPI_ASSERT_IMP(a_write_free_bank, mem_we_o, !bank_full_q[wb_q], "write into a full bank")
  `OCPI_ASSERT_IMP(a_read_full_bank, mem_re_o, bank_full_q[rb_q] && !mem_we_o, "bad bank read")

endmodule

### rtl/ocpi_fifo.sv
// Result queue between the front end and the output stream.
// Depends on ocpi_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "ofdm_cyclic_prefix_inserter_macros.svh"

module ocpi_fifo
  import ocpi_pkg::*;
#(
  localparam int PW = $clog2(QUEUE_DEPTH),
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  result_t       entry_i,
  input  logic          pop_i,
  output logic          valid_o,
  output result_t       head_o,
  output logic [CW-1:0] count_o
);

  result_t       mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] count_q, count_d;

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_q];
  assign count_o = count_q;

  `OCPI_ASSERT_IMP(a_no_overflow, push_i, (32'(count_q) < QUEUE_DEPTH) || pop_i, "queue overflow")
  `OCPI_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + CW'(1), "count")

endmodule

### rtl/ofdm_cyclic_prefix_inserter.sv
// OFDM cyclic prefix inserter: one input transaction per cycle when ready, push or output tick.
// A pushed sample is written into the two-bank store in its accept cycle; a tick that
// finds a completed bank reads the store, and the sample is written into the four-entry
// result queue in the cycle after acceptance, and then leaves on the output from the
// queue head. Status transactions take the same path. The input accepts one transaction
// per cycle while the queue and the read stage together hold fewer than four results, so
// the sustained rate is one transaction per clock while the output keeps taking results.
// Depends on ocpi_pkg, ocpi_front, ocpi_store and ocpi_fifo.
`timescale 1ns / 1ps

module ofdm_cyclic_prefix_inserter
  import ocpi_pkg::*;
#(
  parameter int MAX_SYMBOL  = 2048,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [31:0]          s_axis_tdata_i,  // [31:0] sample_in
  input  logic [1:0]           s_axis_tuser_i,  // [0] operation, [1] frame_start
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [31:0]          m_axis_tdata_o,  // [31:0] sample_out
  output logic                 m_axis_tlast_o,
  output logic [1:0]           m_axis_tuser_o   // [1:0] status
);

  localparam int IW = $clog2(MAX_SYMBOL);
  localparam int AW = IW + 1;
  localparam int SW = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cfg_t          cfg_q;
  logic          accept;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [SW-1:0] mem_wdata, mem_rdata;
  res_ctl_t      res;
  result_t       entry, head;
  logic [CW-1:0] count;
  logic          q_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.symbol_len       <= CFG_W'(64);
      cfg_q.prefix_len       <= CFG_W'(16);
      cfg_q.first_prefix_len <= CFG_W'(16);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SYMBOL_LEN:       cfg_q.symbol_len       <= cfg_wdata_i;
        CFG_PREFIX_LEN:       cfg_q.prefix_len       <= cfg_wdata_i;
        CFG_FIRST_PREFIX_LEN: cfg_q.first_prefix_len <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready_o = (32'(count) + 32'(res.valid)) < QUEUE_DEPTH;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  ocpi_front #(
    .MAX_SYMBOL (MAX_SYMBOL),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (accept),
    .op_i         (op_e'(s_axis_tuser_i[0])),
    .sample_i     (s_axis_tdata_i),
    .frame_start_i(s_axis_tuser_i[1]),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .res_o        (res)
  );

  ocpi_store #(
    .AW(AW),
    .DW(SW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign entry.sample = res.is_data ? SAMPLE_W'(mem_rdata) : '0;
  assign entry.last   = res.last;
  assign entry.status = res.status;

  ocpi_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res.valid),
    .entry_i(entry),
    .pop_i  (q_valid && m_axis_tready_i),
    .valid_o(q_valid),
    .head_o (head),
    .count_o(count)
  );

  assign m_axis_tvalid_o = q_valid;
  assign m_axis_tdata_o  = head.sample;
  assign m_axis_tlast_o  = head.last;
  assign m_axis_tuser_o  = head.status;

endmodule
